// ===== src/canrt_pkg.sv =====
// ----------------------------------------------------------------------------
// canrt_pkg
// Shared types and constants for the nearest resource table.
// ----------------------------------------------------------------------------
package canrt_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int MAX_HOLDERS   = 8;
   localparam int CATEGORIES    = 8;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
   localparam int HOLD_IDX_W    = $clog2(MAX_HOLDERS);

   typedef enum logic [2:0] {
      CMD_REGISTER   = 3'd0,
      CMD_UNREGISTER = 3'd1,
      CMD_FIND       = 3'd2,
      CMD_RESERVE    = 3'd3,
      CMD_RELEASE    = 3'd4
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_UNKNOWN = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_ACT,
      ST_HOLD,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [2:0]         command;
      logic [15:0]        entity;
      logic [15:0]        user;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic [3:0]         user_limit;
      logic [7:0]         initial_count;
      logic [7:0]         category_mask;
      logic [2:0]         category;
      logic [15:0]        max_distance;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] found_entity;
      logic        granted;
      logic [1:0]  status;
   } rsp_payload_type;

   typedef struct packed {
      logic [15:0]        id;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic [3:0]         limit;
      logic [7:0]         count;
      logic [7:0]         mask;
      logic [31:0]        age;
   } slot_row_type;

   typedef struct packed {
      logic [MAX_HOLDERS-1:0]       valid;
      logic [MAX_HOLDERS-1:0][15:0] id;
   } holder_row_type;

endpackage

// ===== src/capacity_aware_nearest_resource_table.sv =====
// ----------------------------------------------------------------------------
// capacity_aware_nearest_resource_table
// Resource table with register, unregister, nearest search, reserve, release.
// ----------------------------------------------------------------------------
// One word at a time. Every command sweeps all 64 slots of the slot memory,
// one read per cycle, through a two-stage compare pipe (squares, then sum and
// best-so-far). After acceptance a word passes the scan, drain, action and
// result states; reserve and release add a hold state for their holder memory
// read-modify-write. The single slot memory read port paces the scan.
// A new word is taken while the previous result still waits on rsp_; the
// next result then waits until that one is taken. Slot valid bits are flops
// cleared by reset; holder rows are rewritten empty on every register, so
// neither memory needs a clearing pass.
module capacity_aware_nearest_resource_table
   import canrt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   // memories
   slot_row_type   slot_mem [TABLE_ENTRIES];
   holder_row_type hold_mem [TABLE_ENTRIES];

   state_type state_ff, state_in;
   logic [TABLE_ENTRIES-1:0] slot_valid_ff, slot_valid_in;
   logic [31:0]     age_ff, age_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   req_payload_type req_ff, req_in;
   logic [31:0]     radius2_ff, radius2_in;

   // scan pipe
   slot_row_type    rd_row_ff;
   holder_row_type  hrow_ff;
   logic            s1_v_ff, s1_v_in;
   logic [IDX_W-1:0] s1_idx_ff;
   logic            s2_v_ff, s2_v_in;
   logic            s2_qual_ff, s2_qual_in;
   logic [32:0]     sqx_ff, sqy_ff, sqz_ff, sqx_in, sqy_in, sqz_in;
   logic [31:0]     s2_age_ff;
   logic [15:0]     s2_id_ff;

   // scan results
   logic            match_ff, match_in, free_ff, free_in, have_ff, have_in;
   logic [IDX_W-1:0] match_idx_ff, match_idx_in, free_idx_ff, free_idx_in;
   slot_row_type    match_row_ff, match_row_in;
   logic [34:0]     best_d_ff, best_d_in;
   logic [31:0]     best_age_ff, best_age_in;
   logic [15:0]     best_id_ff, best_id_in;

   rsp_payload_type res_ff, res_in, rsp_data_ff, rsp_data_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // write ports
   logic            slot_we, hold_we;
   logic [IDX_W-1:0] slot_waddr, hold_waddr;
   slot_row_type    slot_wdata;
   holder_row_type  hold_wdata;

   // stage 1 helpers
   logic            s1_slot_valid;
   logic signed [16:0] dx, dy, dz;
   logic signed [33:0] px, py, pz;
   logic [34:0]     sum_sq;

   // holder update helpers
   logic            h_hit, h_free;
   logic [HOLD_IDX_W-1:0] h_hit_k, h_free_k;

   assign s1_slot_valid = slot_valid_ff[s1_idx_ff];
   assign dx = 17'(req_ff.pos_x) - 17'(rd_row_ff.pos_x);
   assign dy = 17'(req_ff.pos_y) - 17'(rd_row_ff.pos_y);
   assign dz = 17'(req_ff.pos_z) - 17'(rd_row_ff.pos_z);
   assign px = dx * dx;
   assign py = dy * dy;
   assign pz = dz * dz;
   assign sum_sq = 35'(sqx_ff) + 35'(sqy_ff) + 35'(sqz_ff);

   // holder row search: first listed match, first empty entry
   always_comb begin
      h_hit    = 1'b0;
      h_free   = 1'b0;
      h_hit_k  = '0;
      h_free_k = '0;
      for (int k = 0; k < MAX_HOLDERS; k++) begin
         if (hrow_ff.valid[k] && hrow_ff.id[k] == req_ff.user && !h_hit) begin
            h_hit   = 1'b1;
            h_hit_k = HOLD_IDX_W'(k);
         end
         if (!hrow_ff.valid[k] && !h_free) begin
            h_free   = 1'b1;
            h_free_k = HOLD_IDX_W'(k);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      slot_valid_in = slot_valid_ff;
      age_in        = age_ff;
      idx_in        = idx_ff;
      req_in        = req_ff;
      radius2_in    = radius2_ff;
      s1_v_in       = 1'b0;
      s2_v_in       = s1_v_ff;
      s2_qual_in    = 1'b0;
      sqx_in        = px[32:0];
      sqy_in        = py[32:0];
      sqz_in        = pz[32:0];
      match_in      = match_ff;
      match_idx_in  = match_idx_ff;
      match_row_in  = match_row_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      have_in       = have_ff;
      best_d_in     = best_d_ff;
      best_age_in   = best_age_ff;
      best_id_in    = best_id_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      slot_we       = 1'b0;
      slot_waddr    = match_idx_ff;
      slot_wdata    = match_row_ff;
      hold_we       = 1'b0;
      hold_waddr    = match_idx_ff;
      hold_wdata    = hrow_ff;
      req_ready     = (state_ff == ST_IDLE);

      // stage 1: id match, first free slot, search qualification
      if (s1_v_ff) begin
         if (s1_slot_valid && rd_row_ff.id == req_ff.entity && !match_ff) begin
            match_in     = 1'b1;
            match_idx_in = s1_idx_ff;
            match_row_in = rd_row_ff;
         end
         if (!s1_slot_valid && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = s1_idx_ff;
         end
         s2_qual_in = s1_slot_valid && (32'(req_ff.category) < CATEGORIES)
                      && rd_row_ff.mask[req_ff.category]
                      && (rd_row_ff.count < {4'b0, rd_row_ff.limit});
      end

      // stage 2: radius check and best-so-far, earliest age on a tie
      if (s2_v_ff && s2_qual_ff && sum_sq < 35'(radius2_ff)) begin
         if (!have_ff || sum_sq < best_d_ff
             || (sum_sq == best_d_ff && s2_age_ff < best_age_ff)) begin
            have_in     = 1'b1;
            best_d_in   = sum_sq;
            best_age_in = s2_age_ff;
            best_id_in  = s2_id_ff;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in     = req_data;
               radius2_in = 32'(req_data.max_distance) * 32'(req_data.max_distance);
               idx_in     = '0;
               match_in   = 1'b0;
               free_in    = 1'b0;
               have_in    = 1'b0;
               res_in     = '0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            s1_v_in = 1'b1;
            idx_in  = idx_ff + 1'b1;
            if (idx_ff == CNT_W'(TABLE_ENTRIES - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!s1_v_ff && !s2_v_ff) begin
               state_in = ST_ACT;
            end
         end
         ST_ACT: begin
            state_in = ST_RESP;
            case (req_ff.command)
               CMD_REGISTER: begin
                  if (match_ff || free_ff) begin
                     slot_waddr            = match_ff ? match_idx_ff : free_idx_ff;
                     slot_we               = 1'b1;
                     slot_wdata.id         = req_ff.entity;
                     slot_wdata.pos_x      = req_ff.pos_x;
                     slot_wdata.pos_y      = req_ff.pos_y;
                     slot_wdata.pos_z      = req_ff.pos_z;
                     slot_wdata.limit      = req_ff.user_limit;
                     slot_wdata.count      = req_ff.initial_count;
                     slot_wdata.mask       = req_ff.category_mask;
                     slot_wdata.age        = age_ff;
                     hold_we               = 1'b1;
                     hold_waddr            = slot_waddr;
                     hold_wdata            = '0;
                     slot_valid_in[slot_waddr] = 1'b1;
                     age_in                = age_ff + 32'd1;
                  end else begin
                     res_in.status = STATUS_FULL;
                  end
               end
               CMD_UNREGISTER: begin
                  if (match_ff) begin
                     slot_valid_in[match_idx_ff] = 1'b0;
                  end else begin
                     res_in.status = STATUS_UNKNOWN;
                  end
               end
               CMD_FIND: begin
                  res_in.found_entity = have_ff ? best_id_ff : 16'd0;
               end
               CMD_RESERVE, CMD_RELEASE: begin
                  if (match_ff) begin
                     state_in = ST_HOLD;   // holder row arrives next cycle
                  end else begin
                     res_in.status = STATUS_UNKNOWN;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_HOLD: begin
            state_in = ST_RESP;
            if (req_ff.command == CMD_RESERVE) begin
               if (h_hit) begin
                  res_in.granted = 1'b1;
               end else if (match_row_ff.count < {4'b0, match_row_ff.limit} && h_free) begin
                  hold_we                      = 1'b1;
                  hold_wdata.valid[h_free_k]   = 1'b1;
                  hold_wdata.id[h_free_k]      = req_ff.user;
                  slot_we                      = 1'b1;
                  slot_wdata.count             = match_row_ff.count + 8'd1;
                  res_in.granted               = 1'b1;
               end
            end else if (h_hit) begin
               hold_we                  = 1'b1;
               hold_wdata.valid[h_hit_k] = 1'b0;
               if (match_row_ff.count != 8'd0) begin
                  slot_we          = 1'b1;
                  slot_wdata.count = match_row_ff.count - 8'd1;
               end
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slot_valid_ff <= '0;
         age_ff        <= '0;
         s1_v_ff       <= 1'b0;
         s2_v_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_valid_ff <= slot_valid_in;
         age_ff        <= age_in;
         s1_v_ff       <= s1_v_in;
         s2_v_ff       <= s2_v_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      req_ff       <= req_in;
      radius2_ff   <= radius2_in;
      s1_idx_ff    <= idx_ff[IDX_W-1:0];
      s2_qual_ff   <= s2_qual_in;
      sqx_ff       <= sqx_in;
      sqy_ff       <= sqy_in;
      sqz_ff       <= sqz_in;
      s2_age_ff    <= rd_row_ff.age;
      s2_id_ff     <= rd_row_ff.id;
      match_ff     <= match_in;
      match_idx_ff <= match_idx_in;
      match_row_ff <= match_row_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      have_ff      <= have_in;
      best_d_ff    <= best_d_in;
      best_age_ff  <= best_age_in;
      best_id_ff   <= best_id_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // slot memory
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      rd_row_ff <= slot_mem[idx_ff[IDX_W-1:0]];
   end

   // holder memory
   always_ff @(posedge clock) begin
      if (hold_we) begin
         hold_mem[hold_waddr] <= hold_wdata;
      end
      hrow_ff <= hold_mem[match_idx_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/canrt_checker.sv =====
// ----------------------------------------------------------------------------
// canrt_checker
// Port-level checks for the nearest resource table.
// ----------------------------------------------------------------------------
module canrt_checker
   import canrt_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed while stalled");

   // one word in flight: no accept right after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word taken while busy");

   // a grant carries no error and no search hit
   a_grant_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.granted |->
         rsp_data.status == STATUS_OK && rsp_data.found_entity == 16'd0)
      else $error("grant with error or id");

   // an error carries nothing else
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_OK |->
         !rsp_data.granted && rsp_data.found_entity == 16'd0)
      else $error("error word with payload");

   // nothing is offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind capacity_aware_nearest_resource_table canrt_checker u_canrt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/sv/tb_capacity_aware_nearest_resource_table.sv =====
// ----------------------------------------------------------------------------
// tb_capacity_aware_nearest_resource_table
// Drives command words through the resource table under varied flow control
// and checks each result word against an in-bench prediction of the table.
// ----------------------------------------------------------------------------
module tb_capacity_aware_nearest_resource_table
   import canrt_pkg::*;
();

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 200;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_data;

   capacity_aware_nearest_resource_table u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   // Shadow copy of the table.
   logic        tbl_valid [TABLE_ENTRIES];
   logic [15:0] tbl_id    [TABLE_ENTRIES];
   logic signed [15:0] tbl_x [TABLE_ENTRIES];
   logic signed [15:0] tbl_y [TABLE_ENTRIES];
   logic signed [15:0] tbl_z [TABLE_ENTRIES];
   logic [3:0]  tbl_limit [TABLE_ENTRIES];
   logic [7:0]  tbl_count [TABLE_ENTRIES];
   logic [7:0]  tbl_mask  [TABLE_ENTRIES];
   logic [31:0] tbl_age   [TABLE_ENTRIES];
   logic [31:0] next_age;
   logic        usr_valid [TABLE_ENTRIES][MAX_HOLDERS];
   logic [15:0] usr_id    [TABLE_ENTRIES][MAX_HOLDERS];

   req_payload_type pending_words[$];
   rsp_payload_type expected_rsps[$];
   int  error_count;
   int  cycle_count;
   int  send_idle_pct;
   int  recv_stall_pct;
   int  hold_off_cycles;

   function automatic int lookup_slot(logic [15:0] id);
      for (int i = 0; i < TABLE_ENTRIES; i++)
         if (tbl_valid[i] && tbl_id[i] == id) return i;
      return -1;
   endfunction

   function automatic logic [33:0] dist_sq(logic signed [15:0] a, logic signed [15:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      return 34'(d * d);
   endfunction

   // Apply one word to the shadow table and return the result it should give.
   function automatic rsp_payload_type table_apply(req_payload_type w);
      rsp_payload_type r;
      int s;
      int free_h;
      bit have;
      logic [35:0] d;
      logic [35:0] best_d;
      logic [31:0] best_age;
      logic [35:0] radius2;
      r = '0;
      s = -1;
      case (w.command)
         CMD_REGISTER: begin
            s = lookup_slot(w.entity);
            if (s < 0)
               for (int i = 0; i < TABLE_ENTRIES; i++)
                  if (!tbl_valid[i]) begin s = i; break; end
            if (s < 0) begin
               r.status = STATUS_FULL;
            end else begin
               tbl_valid[s] = 1'b1;
               tbl_id[s]    = w.entity;
               tbl_x[s]     = w.pos_x;
               tbl_y[s]     = w.pos_y;
               tbl_z[s]     = w.pos_z;
               tbl_limit[s] = w.user_limit;
               tbl_count[s] = w.initial_count;
               tbl_mask[s]  = w.category_mask;
               tbl_age[s]   = next_age;
               next_age     = next_age + 32'd1;
               for (int h = 0; h < MAX_HOLDERS; h++) usr_valid[s][h] = 1'b0;
            end
         end
         CMD_UNREGISTER: begin
            s = lookup_slot(w.entity);
            if (s < 0) r.status = STATUS_UNKNOWN;
            else begin
               tbl_valid[s] = 1'b0;
               for (int h = 0; h < MAX_HOLDERS; h++) usr_valid[s][h] = 1'b0;
            end
         end
         CMD_FIND: begin
            have     = 1'b0;
            best_d   = '0;
            best_age = '0;
            radius2  = 36'(w.max_distance) * 36'(w.max_distance);
            if (int'(w.category) < CATEGORIES)
               for (int i = 0; i < TABLE_ENTRIES; i++) begin
                  if (!tbl_valid[i] || !tbl_mask[i][w.category]) continue;
                  if (tbl_count[i] >= 8'(tbl_limit[i])) continue;
                  d = 36'(dist_sq(w.pos_x, tbl_x[i])) + 36'(dist_sq(w.pos_y, tbl_y[i]))
                      + 36'(dist_sq(w.pos_z, tbl_z[i]));
                  if (d >= radius2) continue;
                  if (!have || d < best_d || (d == best_d && tbl_age[i] < best_age)) begin
                     have           = 1'b1;
                     best_d         = d;
                     best_age       = tbl_age[i];
                     r.found_entity = tbl_id[i];
                  end
               end
         end
         CMD_RESERVE: begin
            s = lookup_slot(w.entity);
            if (s < 0) r.status = STATUS_UNKNOWN;
            else begin
               free_h = -1;
               for (int h = 0; h < MAX_HOLDERS; h++) begin
                  if (usr_valid[s][h] && usr_id[s][h] == w.user) begin
                     r.granted = 1'b1;
                     break;
                  end
                  if (!usr_valid[s][h] && free_h < 0) free_h = h;
               end
               if (!r.granted && tbl_count[s] < 8'(tbl_limit[s]) && free_h >= 0) begin
                  usr_valid[s][free_h] = 1'b1;
                  usr_id[s][free_h]    = w.user;
                  tbl_count[s]         = tbl_count[s] + 8'd1;
                  r.granted            = 1'b1;
               end
            end
         end
         CMD_RELEASE: begin
            s = lookup_slot(w.entity);
            if (s < 0) r.status = STATUS_UNKNOWN;
            else
               for (int h = 0; h < MAX_HOLDERS; h++)
                  if (usr_valid[s][h] && usr_id[s][h] == w.user) begin
                     usr_valid[s][h] = 1'b0;
                     if (tbl_count[s] > 0) tbl_count[s] = tbl_count[s] - 8'd1;
                     break;
                  end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      error_count++;
   endtask

   // Append a word to the stimulus queue.
   task automatic queue_word(req_payload_type w);
      pending_words.insert(pending_words.size(), w);
   endtask

   // Word builder; random fields everywhere, caller overrides what matters.
   function automatic req_payload_type random_word();
      req_payload_type w;
      w.command       = 3'($urandom_range(0, 7));
      w.entity        = 16'($urandom);
      w.user          = 16'($urandom);
      w.pos_x         = 16'($urandom);
      w.pos_y         = 16'($urandom);
      w.pos_z         = 16'($urandom);
      w.user_limit    = 4'($urandom);
      w.initial_count = 8'($urandom);
      w.category_mask = 8'($urandom);
      w.category      = 3'($urandom);
      w.max_distance  = 16'($urandom);
      return w;
   endfunction

   // Small id pool so commands keep hitting registered entries.
   function automatic logic [15:0] pool_id();
      if ($urandom_range(0, 19) == 0) return 16'($urandom);
      return 16'($urandom_range(0, 11));
   endfunction

   function automatic logic signed [15:0] near_coord();
      if ($urandom_range(0, 9) == 0) return 16'($urandom);
      return 16'($signed($urandom_range(0, 200)) - 100);
   endfunction

   function automatic req_payload_type pool_word();
      req_payload_type w;
      int pick;
      w      = random_word();
      pick   = $urandom_range(0, 99);
      w.entity = pool_id();
      w.user   = 16'($urandom_range(0, 11));
      w.pos_x  = near_coord();
      w.pos_y  = near_coord();
      w.pos_z  = near_coord();
      if (pick < 25) begin
         w.command       = CMD_REGISTER;
         w.user_limit    = 4'($urandom_range(0, 8));
         w.initial_count = 8'($urandom_range(0, 3));
      end else if (pick < 32) w.command = CMD_UNREGISTER;
      else if (pick < 57) begin
         w.command      = CMD_FIND;
         w.max_distance = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 400));
      end else if (pick < 77) w.command = CMD_RESERVE;
      else if (pick < 95) w.command = CMD_RELEASE;
      return w;
   endfunction

   task automatic wait_drained();
      while (pending_words.size() != 0 || expected_rsps.size() != 0) @(posedge clock);
   endtask

   // Driver: one word offered at a time, held until accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         // retire the accepted word, then offer the next one or idle
         if (req_valid) void'(pending_words.pop_front());
         if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= pending_words[0];
            expected_rsps.insert(expected_rsps.size(), table_apply(pending_words[0]));
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver back-pressure, with a long hold-off when requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ready       <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Monitor: compare each accepted result word with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected word", 1, 0);
         end else begin
            if (rsp_data.found_entity != expected_rsps[0].found_entity)
               report_mismatch("found_entity", rsp_data.found_entity,
                               expected_rsps[0].found_entity);
            if (rsp_data.granted != expected_rsps[0].granted)
               report_mismatch("granted", rsp_data.granted, expected_rsps[0].granted);
            if (rsp_data.status != expected_rsps[0].status)
               report_mismatch("status", rsp_data.status, expected_rsps[0].status);
            void'(expected_rsps.pop_front());
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      req_payload_type w;
      error_count     = 0;
      cycle_count     = 0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      hold_off_cycles = 0;
      next_age        = '0;
      req_valid       = 1'b0;
      req_data        = '0;
      rsp_ready       = 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         tbl_valid[i] = 1'b0;
         for (int h = 0; h < MAX_HOLDERS; h++) usr_valid[i][h] = 1'b0;
      end
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: unknown ids, extremes, ties, capacity, id zero, unused codes.
      w = '0; w.command = CMD_RESERVE; w.entity = 16'd5; queue_word(w);
      w.command = CMD_RELEASE; queue_word(w);
      w.command = CMD_UNREGISTER; queue_word(w);
      w = '0; w.command = CMD_REGISTER; w.entity = 16'd0; w.user_limit = 4'd8;
      w.category_mask = 8'hFF; queue_word(w);
      w.entity = 16'hFFFF; w.pos_x = 16'sh7FFF; w.pos_y = -16'sd32768; w.pos_z = 16'sh7FFF;
      w.user_limit = 4'hF; w.initial_count = 8'hFF; queue_word(w);
      w.entity = 16'd7; w.pos_x = -16'sd32768; w.pos_y = 16'sh7FFF; w.pos_z = -16'sd32768;
      w.user_limit = 4'd1; w.initial_count = 8'd0; w.category_mask = 8'h80;
      queue_word(w);
      w = '0; w.command = CMD_REGISTER; w.entity = 16'd9; w.user_limit = 4'd2;
      w.category_mask = 8'h01; w.pos_x = 16'sd3; queue_word(w);
      w.entity = 16'd10; w.pos_x = -16'sd3; queue_word(w);                 // distance tie
      w = '0; w.command = CMD_FIND; w.category = 3'd0; w.max_distance = 16'd4;
      queue_word(w);
      w.max_distance = 16'd3; queue_word(w);                               // strict compare
      w.max_distance = 16'hFFFF; w.category = 3'd7; w.pos_x = 16'sh7FFF;
      w.pos_y = 16'sh7FFF; w.pos_z = 16'sh7FFF; queue_word(w);
      w = '0; w.command = CMD_RESERVE; w.entity = 16'd7; w.user = 16'hFFFF;
      queue_word(w);
      queue_word(w);                                                       // already listed
      w.user = 16'd1; queue_word(w);                                       // over limit
      w.command = CMD_RELEASE; queue_word(w);                              // not listed
      w.user = 16'hFFFF; queue_word(w);
      w = '0; w.command = CMD_REGISTER; w.entity = 16'd9; w.user_limit = 4'd3;
      w.category_mask = 8'h02; queue_word(w);                              // re-register
      w = '0; w.command = CMD_FIND; w.category = 3'd0; w.max_distance = 16'd10;
      queue_word(w);
      w = '1; w.command = 3'd5; queue_word(w);
      w.command = 3'd7; queue_word(w);
      wait_drained();

      // Register one id more than the table holds, on top of the directed entries.
      for (int i = 0; i <= TABLE_ENTRIES; i++) begin
         w = random_word(); w.command = CMD_REGISTER; w.entity = 16'(1000 + i);
         queue_word(w);
      end
      w = random_word(); w.command = CMD_FIND; queue_word(w);
      wait_drained();
      for (int i = 0; i <= TABLE_ENTRIES; i++) begin
         w = random_word(); w.command = CMD_UNREGISTER; w.entity = 16'(1000 + i);
         queue_word(w);
      end
      wait_drained();

      // Random phases with varying flow control.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
            3: begin send_idle_pct = 35; recv_stall_pct = 35; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         if (ph == 4) hold_off_cycles = 600;   // fill the block and stall req_
         for (int n = 0; n < 70; n++) begin
            w = ($urandom_range(0, 9) == 0) ? random_word() : pool_word();
            queue_word(w);
         end
         wait_drained();
      end
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

// ===== capacity_aware_nearest_resource_table.f =====
src/canrt_pkg.sv
src/capacity_aware_nearest_resource_table.sv
src/canrt_checker.sv
tb/sv/tb_capacity_aware_nearest_resource_table.sv
